### src/tocq_pkg.sv
// Shared constants, types and helper functions for the timed output command queue.
package tocq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int NUM_JETS    = 32;
	localparam int TIME_W      = 32;
	localparam int JET_PORT_W  = 32;
	localparam int COUNT_W     = 4;
	localparam int DIV_W       = 8;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [DIV_W-1:0] TICK_DIVIDE_RESET = DIV_W'(12);

	// register index of tick_divide on the APB port
	localparam logic REG_TICK_DIVIDE = 1'b0;

	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [NUM_JETS-1:0] jets_t;
	typedef logic [COUNT_W-1:0]  count_t;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_FULL_DROP  = 3'd1,
		ST_ORDER_DROP = 3'd2,
		ST_SKIPPED    = 3'd3,
		ST_IDLE       = 3'd4,
		ST_FIRED      = 3'd5
	} status_t;

	typedef enum logic {
		CS_IDLE,
		CS_CHECK
	} ctrl_state_t;

	// request to the command store: one write and one read port
	typedef struct packed {
		logic  wr_en;
		ptr_t  wr_addr;
		time_t wr_time;
		jets_t wr_bits;
		logic  rd_en;
		ptr_t  rd_addr;
	} mem_req_t;

	// registered read data from the command store
	typedef struct packed {
		time_t rd_time;
		jets_t rd_bits;
	} mem_rsp_t;

	// advance a ring index with wrap
	function automatic ptr_t next_slot(ptr_t idx);
		ptr_t n;
		if (idx == ptr_t'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = idx + ptr_t'(1);
		end
		return n;
	endfunction

	// number of waiting commands, masked to the count width
	function automatic count_t waiting(ptr_t head, ptr_t tail);
		logic [PTR_W:0] diff;
		if (tail >= head) begin
			diff = {1'b0, tail} - {1'b0, head};
		end else begin
			diff = {1'b0, tail} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, head};
		end
		return COUNT_W'(diff);
	endfunction

endpackage

### src/tocq_store.sv
// Command store: trigger times and jet bits, one write and one registered read per cycle.
module tocq_store (
	input  logic             clk,
	input  tocq_pkg::mem_req_t req,
	output tocq_pkg::mem_rsp_t rsp
);
	import tocq_pkg::*;

	time_t time_mem [QUEUE_DEPTH];
	jets_t bits_mem [QUEUE_DEPTH];

	// write the tail entry on an accepted add
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			time_mem[req.wr_addr] <= req.wr_time;
			bits_mem[req.wr_addr] <= req.wr_bits;
		end
	end

	// read the head entry, data valid in the following cycle
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rsp.rd_time <= time_mem[req.rd_addr];
			rsp.rd_bits <= bits_mem[req.rd_addr];
		end
	end

endmodule

### src/tocq_ctrl.sv
// Queue controller: ring pointers, order and due checks, prescaler, jet latch and result register.
module tocq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tocq_pkg::DIV_W-1:0]   tick_divide,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [tocq_pkg::TIME_W-1:0]  cmd_time,
	input  logic [tocq_pkg::NUM_JETS-1:0] jet_bits,
	input  logic [tocq_pkg::TIME_W-1:0]  now_time,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tocq_pkg::status_t            status,
	output logic [tocq_pkg::NUM_JETS-1:0] jet_latch,
	output logic [tocq_pkg::COUNT_W-1:0] queue_count,
	output tocq_pkg::mem_req_t           mem_req,
	input  tocq_pkg::mem_rsp_t           mem_rsp
);
	import tocq_pkg::*;

	ctrl_state_t       state_q, state_d;
	ptr_t              head_q, head_d;
	ptr_t              tail_q, tail_d;
	time_t             last_q, last_d;
	logic [DIV_W-1:0]  presc_q, presc_d;
	jets_t             jet_q, jet_d;
	time_t             now_q, now_d;
	logic              out_valid_q, out_valid_d;
	status_t           status_q, status_d;
	count_t            count_q, count_d;

	logic              accept;
	ptr_t              tail_next;
	ptr_t              head_next;
	time_t             order_diff;
	time_t             due_diff;
	logic [DIV_W-1:0]  presc_inc;

	assign tail_next  = next_slot(tail_q);
	assign head_next  = next_slot(head_q);
	assign order_diff = cmd_time - last_q;
	assign due_diff   = now_q - mem_rsp.rd_time;
	assign presc_inc  = presc_q + DIV_W'(1);

	// take a new beat only from idle and with the result slot free
	assign in_ready = (state_q == CS_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign jet_latch   = jet_q;
	assign queue_count = count_q;

	// next state, memory requests and result loading
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		last_d      = last_q;
		presc_d     = presc_q;
		jet_d       = jet_q;
		now_d       = now_q;
		out_valid_d = out_valid_q && !out_ready;
		status_d    = status_q;
		count_d     = count_q;
		mem_req     = '0;

		case (state_q)
			CS_IDLE: begin
				if (accept) begin
					if (opcode == OP_ADD) begin
						// add: drop when full or out of order, else append at tail
						out_valid_d = 1'b1;
						if (tail_next == head_q) begin
							status_d = ST_FULL_DROP;
						end else if ((tail_q != head_q) && order_diff[TIME_W-1]) begin
							status_d = ST_ORDER_DROP;
						end else begin
							status_d        = ST_ACCEPTED;
							last_d          = cmd_time;
							tail_d          = tail_next;
							mem_req.wr_en   = 1'b1;
							mem_req.wr_addr = tail_q;
							mem_req.wr_time = cmd_time;
							mem_req.wr_bits = jet_bits;
						end
						count_d = waiting(head_q, tail_d);
					end else begin
						// tick: advance prescaler, read head when a check is due and the queue is not empty
						if (presc_inc < tick_divide) begin
							presc_d     = presc_inc;
							out_valid_d = 1'b1;
							status_d    = ST_SKIPPED;
							count_d     = waiting(head_q, tail_q);
						end else begin
							presc_d = '0;
							if (head_q == tail_q) begin
								out_valid_d = 1'b1;
								status_d    = ST_IDLE;
								count_d     = waiting(head_q, tail_q);
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = head_q;
								now_d           = now_time;
								state_d         = CS_CHECK;
							end
						end
					end
				end
			end
			CS_CHECK: begin
				// fire the head when now is strictly past its time
				out_valid_d = 1'b1;
				if ((due_diff != '0) && !due_diff[TIME_W-1]) begin
					jet_d    = mem_rsp.rd_bits;
					head_d   = head_next;
					status_d = ST_FIRED;
					count_d  = waiting(head_next, tail_q);
				end else begin
					status_d = ST_IDLE;
					count_d  = waiting(head_q, tail_q);
				end
				state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	// control and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			last_q      <= '0;
			presc_q     <= '0;
			jet_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			last_q      <= last_d;
			presc_q     <= presc_d;
			jet_q       <= jet_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		now_q    <= now_d;
		status_q <= status_d;
		count_q  <= count_d;
	end

endmodule

### src/timed_output_command_queue_top.sv
// An add, a skipped tick or a tick on an empty queue shows its result in the cycle after accept.
// A tick that checks a waiting head registers the store read and enters CS_CHECK, then registers its result.
// Throughput: one item per cycle while results drain, none in CS_CHECK; one result held at a time,
// and the next beat is taken in the cycle its predecessor's result is taken.
// Reset (arst_n low, asynchronous): queue empty, jets off, prescaler zero, tick_divide 12.
// Store contents are not cleared; entries are only read after being written.
module timed_output_command_queue_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tocq_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [tocq_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [tocq_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [tocq_pkg::TIME_W-1:0]       cmd_time,
	input  logic [tocq_pkg::JET_PORT_W-1:0]   jet_bits,
	input  logic [tocq_pkg::TIME_W-1:0]       now_time,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        status,
	output logic [tocq_pkg::JET_PORT_W-1:0]   jet_drive,
	output logic [tocq_pkg::COUNT_W-1:0]      queue_count
);
	import tocq_pkg::*;

	logic [DIV_W-1:0] tick_divide_q;
	logic             reg_sel;
	mem_req_t         mem_req;
	mem_rsp_t         mem_rsp;
	status_t          status_w;
	jets_t            jet_w;

	// register file: tick_divide at word 0, other words read as zero
	assign reg_sel = (paddr[2] == REG_TICK_DIVIDE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DATA_W'(tick_divide_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divide_q <= TICK_DIVIDE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			tick_divide_q <= pwdata[DIV_W-1:0];
		end
	end

	tocq_store u_store (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

	tocq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_divide (tick_divide_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.cmd_time    (cmd_time),
		.jet_bits    (NUM_JETS'(jet_bits)),
		.now_time    (now_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status_w),
		.jet_latch   (jet_w),
		.queue_count (queue_count),
		.mem_req     (mem_req),
		.mem_rsp     (mem_rsp)
	);

	assign status    = status_w;
	assign jet_drive = JET_PORT_W'(jet_w);

endmodule

### src/tocq_checker.sv
// Port-level checker for the timed output command queue, bound to the top level.
module tocq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [2:0]                        status,
	input logic [tocq_pkg::JET_PORT_W-1:0]   jet_drive,
	input logic [tocq_pkg::COUNT_W-1:0]      queue_count
);
	import tocq_pkg::*;

	// a beat is taken only when the result slot is free or draining
	a_accept_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (!out_valid || out_ready))
		else $error("input beat taken while result slot is blocked");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(jet_drive)
			&& $stable(queue_count)))
		else $error("stalled result changed");

	// an accepted add leaves at least one command waiting
	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_ACCEPTED)) |-> (queue_count != '0))
		else $error("accepted add with empty queue");

	// a full drop reports a full queue
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL_DROP)) |-> (queue_count == COUNT_W'(QUEUE_DEPTH - 1)))
		else $error("full drop with queue not full");

	// jets change only together with a fired result
	a_jet_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(jet_drive) |-> (out_valid && (status == ST_FIRED)))
		else $error("jet outputs changed without a fired result");

endmodule

bind timed_output_command_queue_top tocq_checker u_checker (.*);
